/* design/stp_pkg.sv */
// ----------------------------------------------------------------------------
// Scrolling trace plot package
// Shared constants, phase codes and the draw command word.
// ----------------------------------------------------------------------------
`default_nettype none

package stp_pkg;

    localparam int COLUMNS_DEF = 128;
    localparam int QUEUE_DEPTH = 2;
    localparam int GAP_RESET   = 16;

    localparam int ROW_BASE  = 55;
    localparam int ROW_SPAN  = 35;
    localparam int SCALE_NUM = 35;
    localparam int SCALE_SH  = 10;
    localparam int WIPE_TOP    = 19;
    localparam int WIPE_BOTTOM = 56;

    // command phases of one sample
    localparam logic [1:0] PH_ERASE = 2'd0;
    localparam logic [1:0] PH_WIPE  = 2'd1;
    localparam logic [1:0] PH_PLOT  = 2'd2;

    localparam logic KIND_PIXEL = 1'b0;
    localparam logic KIND_LINE  = 1'b1;
    localparam logic INK_ERASE  = 1'b0;
    localparam logic INK_DRAW   = 1'b1;

    typedef struct packed {
        logic       draw_kind;
        logic [6:0] x_start;
        logic [5:0] y_start;
        logic [6:0] x_end;
        logic [5:0] y_end;
        logic       ink;
        logic       last_of_run;
    } cmd_t;

endpackage

`default_nettype wire

/* design/stp_front.sv */
// ----------------------------------------------------------------------------
// Scrolling trace plot front end
// Accepts samples, scales them to a row and tracks plot and clear columns.
// ----------------------------------------------------------------------------
`default_nettype none

module stp_front #(
    parameter int COLUMNS = stp_pkg::COLUMNS_DEF,
    localparam int CW = $clog2(COLUMNS)
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          cfg_we,
    input  wire logic [6:0]    cfg_data,
    input  wire logic          push,
    input  wire logic [11:0]   sample,
    output logic               full,
    input  wire logic          q_full,
    input  wire logic          clearing,
    output logic               q_push,
    output logic [5:0]         e_row,
    output logic [5:0]         e_prev,
    output logic [CW-1:0]      e_pcol,
    output logic [CW-1:0]      e_ccol
);

    localparam int GAP_STEPS     = 127 / COLUMNS;
    localparam int GAP_RESET_MOD = stp_pkg::GAP_RESET % COLUMNS;

    logic [CW-1:0] plot_col_reg, plot_col_next;
    logic [CW-1:0] gap_mod_reg, gap_mod_next;
    logic [5:0]    prev_row_reg;
    logic [17:0]   prod;
    logic [7:0]    scaled;
    logic [6:0]    gm;
    logic [CW:0]   csum;

    assign full   = q_full || clearing;
    assign q_push = push && !full;

    assign prod   = 18'(sample) * 18'(stp_pkg::SCALE_NUM);
    assign scaled = prod[17:10];

    always_comb
    begin
        if (scaled <= 8'(stp_pkg::ROW_SPAN))
            e_row = 6'(8'(stp_pkg::ROW_BASE) - scaled);
        else
            e_row = prev_row_reg;
    end

    assign e_prev = prev_row_reg;
    assign e_pcol = plot_col_reg;

    // clear column: plot column plus reduced gap, one wrap at most
    assign csum = {1'b0, plot_col_reg} + {1'b0, gap_mod_reg};
    assign e_ccol = (csum >= (CW+1)'(COLUMNS)) ? CW'(csum - (CW+1)'(COLUMNS)) : CW'(csum);

    assign plot_col_next = (plot_col_reg == CW'(COLUMNS - 1)) ? '0 : plot_col_reg + 1'b1;

    // reduce the gap below the column count once, at write time
    always_comb
    begin
        gm = cfg_data;
        for (int i = 0; i < GAP_STEPS; i++)
        begin
            if (32'(gm) >= COLUMNS)
                gm = gm - 7'(COLUMNS);
        end
        gap_mod_next = CW'({{CW{1'b0}}, gm});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            plot_col_reg <= '0;
            prev_row_reg <= '0;
            gap_mod_reg  <= CW'(GAP_RESET_MOD);
        end
        else
        begin
            if (cfg_we)
                gap_mod_reg <= gap_mod_next;
            if (q_push)
            begin
                plot_col_reg <= plot_col_next;
                prev_row_reg <= e_row;
            end
        end
    end

endmodule

`default_nettype wire

/* design/stp_queue.sv */
// ----------------------------------------------------------------------------
// Scrolling trace plot queue
// Short queue of classified samples between front and back end.
// ----------------------------------------------------------------------------
`default_nettype none

module stp_queue #(
    parameter int DEPTH = stp_pkg::QUEUE_DEPTH,
    parameter int WIDTH = 8,
    localparam int PW = $clog2(DEPTH),
    localparam int NW = $clog2(DEPTH + 1)
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push,
    input  wire logic [WIDTH-1:0] wdata,
    output logic                  q_full,
    input  wire logic             pop,
    output logic [WIDTH-1:0]      rdata,
    output logic                  q_valid
);

    logic [WIDTH-1:0] entry_reg [DEPTH];
    logic [PW-1:0]    wr_ptr_reg, rd_ptr_reg;
    logic [NW-1:0]    count_reg;

    assign q_full  = (count_reg == NW'(DEPTH));
    assign q_valid = (count_reg != '0);
    assign rdata   = entry_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= wdata;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            if (push && !pop)
                count_reg <= count_reg + 1'b1;
            else if (pop && !push)
                count_reg <= count_reg - 1'b1;
        end
    end

endmodule

`default_nettype wire

/* design/stp_back.sv */
// ----------------------------------------------------------------------------
// Scrolling trace plot back end
// Holds the row store, sequences three draw commands per sample.
// ----------------------------------------------------------------------------
`default_nettype none

module stp_back #(
    parameter int COLUMNS = stp_pkg::COLUMNS_DEF,
    localparam int CW = $clog2(COLUMNS)
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          q_valid,
    input  wire logic [5:0]    e_row,
    input  wire logic [5:0]    e_prev,
    input  wire logic [CW-1:0] e_pcol,
    input  wire logic [CW-1:0] e_ccol,
    output logic               q_pop,
    output logic               clearing,
    output logic               empty,
    input  wire logic          pop,
    output stp_pkg::cmd_t      cmd
);

    logic [5:0]    mem [COLUMNS];
    logic [5:0]    rd_a_reg, rd_b_reg;
    logic          mem_we;
    logic [CW-1:0] mem_wa;
    logic [5:0]    mem_wd;
    logic [CW-1:0] rd_addr_a;

    logic          clr_active_reg;
    logic [CW-1:0] clr_addr_reg;

    logic          cur_valid_reg;
    logic [1:0]    phase_reg;
    logic [5:0]    cur_row_reg, cur_prev_reg;
    logic [CW-1:0] cur_pcol_reg, cur_ccol_reg;

    logic          out_valid_reg;
    stp_pkg::cmd_t out_cmd_reg, cmd_next;

    logic issue;
    logic out_load;
    logic out_take;

    function automatic logic [6:0] to_x(input logic [CW-1:0] col);
        to_x = 7'({7'd0, col});
    endfunction

    assign clearing = clr_active_reg;
    assign out_take = pop && out_valid_reg;
    assign out_load = cur_valid_reg && (!out_valid_reg || pop);
    assign issue    = q_valid && !clr_active_reg &&
                      (!cur_valid_reg || (out_load && phase_reg == stp_pkg::PH_PLOT));
    assign q_pop    = issue;

    assign rd_addr_a = (e_ccol == '0) ? '0 : e_ccol - 1'b1;

    // read old rows and store the new one in the same edge (read first)
    assign mem_we = clr_active_reg || issue;
    assign mem_wa = clr_active_reg ? clr_addr_reg : e_pcol;
    assign mem_wd = clr_active_reg ? 6'd0 : e_row;

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_wa] <= mem_wd;
        if (issue)
        begin
            rd_a_reg <= mem[rd_addr_a];
            rd_b_reg <= mem[e_ccol];
        end
    end

    always_ff @(posedge clk)
    begin
        if (issue)
        begin
            cur_row_reg  <= e_row;
            cur_prev_reg <= e_prev;
            cur_pcol_reg <= e_pcol;
            cur_ccol_reg <= e_ccol;
        end
        if (out_load)
            out_cmd_reg <= cmd_next;
    end

    always_comb
    begin
        cmd_next = '0;
        case (phase_reg)
            stp_pkg::PH_ERASE:
            begin
                cmd_next.ink         = stp_pkg::INK_ERASE;
                cmd_next.last_of_run = 1'b0;
                if (cur_ccol_reg == '0)
                begin
                    cmd_next.draw_kind = stp_pkg::KIND_PIXEL;
                    cmd_next.x_start   = 7'd0;
                    cmd_next.y_start   = rd_b_reg;
                    cmd_next.x_end     = 7'd0;
                    cmd_next.y_end     = rd_b_reg;
                end
                else
                begin
                    cmd_next.draw_kind = stp_pkg::KIND_LINE;
                    cmd_next.x_start   = to_x(cur_ccol_reg - 1'b1);
                    cmd_next.y_start   = rd_a_reg;
                    cmd_next.x_end     = to_x(cur_ccol_reg);
                    cmd_next.y_end     = rd_b_reg;
                end
            end
            stp_pkg::PH_WIPE:
            begin
                cmd_next.draw_kind   = stp_pkg::KIND_LINE;
                cmd_next.x_start     = to_x(cur_ccol_reg);
                cmd_next.y_start     = 6'(stp_pkg::WIPE_TOP);
                cmd_next.x_end       = to_x(cur_ccol_reg);
                cmd_next.y_end       = 6'(stp_pkg::WIPE_BOTTOM);
                cmd_next.ink         = stp_pkg::INK_ERASE;
                cmd_next.last_of_run = 1'b0;
            end
            stp_pkg::PH_PLOT:
            begin
                cmd_next.ink         = stp_pkg::INK_DRAW;
                cmd_next.last_of_run = 1'b1;
                if (cur_pcol_reg == '0)
                begin
                    cmd_next.draw_kind = stp_pkg::KIND_PIXEL;
                    cmd_next.x_start   = 7'd0;
                    cmd_next.y_start   = cur_row_reg;
                    cmd_next.x_end     = 7'd0;
                    cmd_next.y_end     = cur_row_reg;
                end
                else
                begin
                    cmd_next.draw_kind = stp_pkg::KIND_LINE;
                    cmd_next.x_start   = to_x(cur_pcol_reg - 1'b1);
                    cmd_next.y_start   = cur_prev_reg;
                    cmd_next.x_end     = to_x(cur_pcol_reg);
                    cmd_next.y_end     = cur_row_reg;
                end
            end
            default:
            begin
                cmd_next = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_active_reg <= 1'b1;
            clr_addr_reg   <= '0;
            cur_valid_reg  <= 1'b0;
            phase_reg      <= stp_pkg::PH_ERASE;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (clr_active_reg)
            begin
                clr_addr_reg <= clr_addr_reg + 1'b1;
                if (clr_addr_reg == CW'(COLUMNS - 1))
                    clr_active_reg <= 1'b0;
            end

            if (issue)
                cur_valid_reg <= 1'b1;
            else if (out_load && phase_reg == stp_pkg::PH_PLOT)
                cur_valid_reg <= 1'b0;

            if (issue)
                phase_reg <= stp_pkg::PH_ERASE;
            else if (out_load)
                phase_reg <= (phase_reg == stp_pkg::PH_PLOT) ? stp_pkg::PH_ERASE
                                                              : phase_reg + 1'b1;

            if (out_load)
                out_valid_reg <= 1'b1;
            else if (out_take)
                out_valid_reg <= 1'b0;
        end
    end

    assign empty = !out_valid_reg;
    assign cmd   = out_cmd_reg;

`ifndef SYNTH
    a_no_issue_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
        clr_active_reg |-> !issue)
        else $error("sample issued during row store clear");

    a_last_on_plot: assert property (@(posedge clk) disable iff (!rst_n)
        (out_load && phase_reg == stp_pkg::PH_PLOT) |=> out_cmd_reg.last_of_run)
        else $error("plot command lost its last flag");

    a_phase_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (cur_valid_reg && !out_load) |=> $stable(phase_reg))
        else $error("phase advanced while output stalled");

    a_word_held: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !pop) |=> (out_valid_reg && $stable(out_cmd_reg)))
        else $error("waiting command word changed");
`endif

endmodule

`default_nettype wire

/* design/scrolling_trace_plot_commands.sv */
// Samples pass the queue and the sample registers; draw words the output register.
// Three words per sample on one port; the next sample issues as the plot word loads.
// Reset: asynchronous, clears columns and previous row, sets the clear gap to 16.
// After reset a clearing pass zeroes every row store entry, one entry per cycle;
// full stays high until it ends.
// ----------------------------------------------------------------------------
// Scrolling trace plot command generator
// Turns converter samples into erase, wipe and plot draw commands.
// ----------------------------------------------------------------------------
`default_nettype none

module scrolling_trace_plot_commands #(
    parameter int COLUMNS = stp_pkg::COLUMNS_DEF,
    localparam int CW = $clog2(COLUMNS)
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic [6:0]  cfg_data,
    input  wire logic        push,
    output logic             full,
    input  wire logic [11:0] sample,
    output logic             empty,
    input  wire logic        pop,
    output logic             draw_kind,
    output logic [6:0]       x_start,
    output logic [5:0]       y_start,
    output logic [6:0]       x_end,
    output logic [5:0]       y_end,
    output logic             ink,
    output logic             last_of_run
);

    localparam int EW = 12 + 2 * CW;

    logic          q_push, q_pop, q_full, q_valid, clearing;
    logic [5:0]    f_row, f_prev, b_row, b_prev;
    logic [CW-1:0] f_pcol, f_ccol, b_pcol, b_ccol;
    logic [EW-1:0] q_rdata;
    stp_pkg::cmd_t cmd;

    stp_front #(
        .COLUMNS (COLUMNS)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_data (cfg_data),
        .push     (push),
        .sample   (sample),
        .full     (full),
        .q_full   (q_full),
        .clearing (clearing),
        .q_push   (q_push),
        .e_row    (f_row),
        .e_prev   (f_prev),
        .e_pcol   (f_pcol),
        .e_ccol   (f_ccol)
    );

    stp_queue #(
        .DEPTH (stp_pkg::QUEUE_DEPTH),
        .WIDTH (EW)
    ) u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (q_push),
        .wdata   ({f_row, f_prev, f_pcol, f_ccol}),
        .q_full  (q_full),
        .pop     (q_pop),
        .rdata   (q_rdata),
        .q_valid (q_valid)
    );

    assign {b_row, b_prev, b_pcol, b_ccol} = q_rdata;

    stp_back #(
        .COLUMNS (COLUMNS)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_valid  (q_valid),
        .e_row    (b_row),
        .e_prev   (b_prev),
        .e_pcol   (b_pcol),
        .e_ccol   (b_ccol),
        .q_pop    (q_pop),
        .clearing (clearing),
        .empty    (empty),
        .pop      (pop),
        .cmd      (cmd)
    );

    assign draw_kind   = cmd.draw_kind;
    assign x_start     = cmd.x_start;
    assign y_start     = cmd.y_start;
    assign x_end       = cmd.x_end;
    assign y_end       = cmd.y_end;
    assign ink         = cmd.ink;
    assign last_of_run = cmd.last_of_run;

endmodule

`default_nettype wire

/* sim/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Scrolling trace plot command testbench
// Pushes converter samples into the block, predicts the erase, wipe and plot
// draw words of each one, and checks every popped word against the oldest
// prediction, under random idling, long back-pressure and several clear gaps.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int NCOLS       = stp_pkg::COLUMNS_DEF;
    localparam int CYCLE_LIMIT = 40000;
    localparam int DRAIN_TAIL  = 6;

    logic        clk      = 1'b0;
    logic        rst_n    = 1'b0;
    logic        cfg_we   = 1'b0;
    logic [6:0]  cfg_data = '0;
    logic        push     = 1'b0;
    logic [11:0] sample   = '0;
    logic        pop      = 1'b0;
    logic        full;
    logic        empty;
    logic        draw_kind;
    logic [6:0]  x_start;
    logic [5:0]  y_start;
    logic [6:0]  x_end;
    logic [5:0]  y_end;
    logic        ink;
    logic        last_of_run;

    scrolling_trace_plot_commands #(
        .COLUMNS(NCOLS)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_we(cfg_we),
        .cfg_data(cfg_data),
        .push(push),
        .full(full),
        .sample(sample),
        .empty(empty),
        .pop(pop),
        .draw_kind(draw_kind),
        .x_start(x_start),
        .y_start(y_start),
        .x_end(x_end),
        .y_end(y_end),
        .ink(ink),
        .last_of_run(last_of_run)
    );

    // predicted draw words, oldest first
    stp_pkg::cmd_t pending_words[$];

    // shadow of the plot state
    logic [5:0] trace_rows[NCOLS];
    logic [6:0] pen_col;
    logic [5:0] last_row;
    logic [6:0] erase_lead;

    int errors        = 0;
    int cycles        = 0;
    bit tx_steady     = 1'b0;
    bit rx_steady     = 1'b0;
    int hold_requests = 0;
    int hold_len      = 0;

    // receiver-side counters
    int            rx_idle   = 0;
    int            hold_left = 0;
    int            hold_seen = 0;
    stp_pkg::cmd_t want;

    always #10 clk = ~clk;

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("scrolling_trace_plot_commands verification failed");
            $finish;
        end
    end

    function automatic void check_field(string name, int exp_val, int act_val);
        if (exp_val != act_val)
        begin
            $error("draw word field %s: expected %0d, actual %0d", name, exp_val, act_val);
            errors++;
        end
    endfunction

    always @(posedge clk)
    begin
        if (pop && !empty)
        begin
            if (pending_words.size() == 0)
            begin
                $error("draw word popped with none predicted");
                errors++;
            end
            else
            begin
                want = pending_words.pop_front();
                check_field("draw_kind", want.draw_kind, draw_kind);
                check_field("x_start", want.x_start, x_start);
                check_field("y_start", want.y_start, y_start);
                check_field("x_end", want.x_end, x_end);
                check_field("y_end", want.y_end, y_end);
                check_field("ink", want.ink, ink);
                check_field("last_of_run", want.last_of_run, last_of_run);
            end
            rx_idle = rx_steady ? 0 : $urandom_range(0, 3);
        end
        // pick up a long hold-off request from the stimulus side
        if (hold_seen != hold_requests)
        begin
            hold_seen = hold_requests;
            hold_left = hold_len;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            pop <= 1'b0;
        end
        else if (rx_idle > 0)
        begin
            rx_idle--;
            pop <= 1'b0;
        end
        else
        begin
            pop <= 1'b1;
        end
    end

    // Work out the three draw words of one sample and advance the plot state.
    task automatic predict_sample(input logic [11:0] s);
        int            scaled;
        logic [5:0]    row;
        logic [6:0]    clr;
        stp_pkg::cmd_t w;
        scaled = (int'(s) * stp_pkg::SCALE_NUM) >> stp_pkg::SCALE_SH;
        row    = (scaled <= stp_pkg::ROW_SPAN) ? 6'(stp_pkg::ROW_BASE - scaled) : last_row;
        clr    = pen_col + erase_lead;

        w.ink         = stp_pkg::INK_ERASE;
        w.last_of_run = 1'b0;
        if (clr == 7'd0)
        begin
            w.draw_kind = stp_pkg::KIND_PIXEL;
            w.x_start   = 7'd0;
            w.y_start   = trace_rows[0];
            w.x_end     = 7'd0;
            w.y_end     = trace_rows[0];
        end
        else
        begin
            w.draw_kind = stp_pkg::KIND_LINE;
            w.x_start   = clr - 7'd1;
            w.y_start   = trace_rows[clr - 7'd1];
            w.x_end     = clr;
            w.y_end     = trace_rows[clr];
        end
        pending_words.push_back(w);

        w.draw_kind = stp_pkg::KIND_LINE;
        w.x_start   = clr;
        w.y_start   = 6'(stp_pkg::WIPE_TOP);
        w.x_end     = clr;
        w.y_end     = 6'(stp_pkg::WIPE_BOTTOM);
        pending_words.push_back(w);

        w.ink         = stp_pkg::INK_DRAW;
        w.last_of_run = 1'b1;
        if (pen_col == 7'd0)
        begin
            w.draw_kind = stp_pkg::KIND_PIXEL;
            w.x_start   = 7'd0;
            w.y_start   = row;
        end
        else
        begin
            w.draw_kind = stp_pkg::KIND_LINE;
            w.x_start   = pen_col - 7'd1;
            w.y_start   = last_row;
        end
        w.x_end = pen_col;
        w.y_end = row;
        pending_words.push_back(w);

        trace_rows[pen_col] = row;
        last_row            = row;
        pen_col             = pen_col + 7'd1;
    endtask

    // Offer one sample; push stays high on return so back-to-back samples need no gap.
    task automatic send_sample(input logic [11:0] s);
        int idle;
        idle = tx_steady ? 0 : $urandom_range(0, 3);
        if (idle > 0)
        begin
            push <= 1'b0;
            repeat (idle) @(posedge clk);
        end
        push   <= 1'b1;
        sample <= s;
        do @(posedge clk); while (full);
        predict_sample(s);
    endtask

    task automatic wait_drained();
        push <= 1'b0;
        while (pending_words.size() != 0) @(posedge clk);
        repeat (DRAIN_TAIL) @(posedge clk);
    endtask

    task automatic write_gap(input logic [6:0] g);
        cfg_we   <= 1'b1;
        cfg_data <= g;
        @(posedge clk);
        cfg_we     <= 1'b0;
        erase_lead = g;
    endtask

    // Mostly in-range rows, with a share of samples that hold the previous row.
    function automatic logic [11:0] draw_sample();
        if ($urandom_range(0, 4) == 0)
            return 12'($urandom_range(1054, 4095));
        return 12'($urandom_range(0, 1053));
    endfunction

    // Reset gap, first plot at column 0, out-of-range samples holding row zero.
    task automatic test_reset_defaults();
        send_sample(12'd4095);
        send_sample(12'd1054);
        send_sample(12'd0);
        send_sample(12'd1053);
        wait_drained();
    endtask

    // Scaling edges: row 55 down to row 20 and the first held sample.
    task automatic test_row_scaling();
        send_sample(12'd29);
        send_sample(12'd30);
        send_sample(12'd1023);
        send_sample(12'd1024);
        send_sample(12'd1052);
        send_sample(12'd1053);
        send_sample(12'd1054);
        send_sample(12'd2048);
        send_sample(12'd4094);
        wait_drained();
    endtask

    // Gap zero reads the plot column before it is written; then max gap,
    // then a gap that lands the clear column on column 0.
    task automatic test_gap_settings();
        write_gap(7'd0);
        send_sample(12'd0);
        send_sample(12'd2048);
        wait_drained();
        write_gap(7'd127);
        send_sample(12'd1053);
        send_sample(12'd4095);
        wait_drained();
        write_gap(7'(NCOLS - int'(pen_col)));
        send_sample(12'd512);
        send_sample(12'd700);
        wait_drained();
    endtask

    // Hold the receiver off while samples keep coming so full asserts.
    task automatic test_long_backpressure();
        write_gap(7'd16);
        hold_len = 60;
        hold_requests++;
        tx_steady = 1'b1;
        repeat (15) send_sample(draw_sample());
        tx_steady = 1'b0;
        wait_drained();
    endtask

    // Random traces over several gaps, wrapping the plot column.
    task automatic test_random_traces();
        logic [6:0] gaps[4];
        gaps[0] = 7'd1;
        gaps[1] = 7'd127;
        gaps[2] = 7'($urandom_range(2, 126));
        gaps[3] = 7'($urandom_range(0, 127));
        for (int ph = 0; ph < 4; ph++)
        begin
            write_gap(gaps[ph]);
            tx_steady = (ph == 1);
            rx_steady = (ph == 1) || (ph == 2);
            repeat (24) send_sample(draw_sample());
            wait_drained();
        end
        tx_steady = 1'b0;
        rx_steady = 1'b0;
    endtask

    initial
    begin
        foreach (trace_rows[i])
            trace_rows[i] = '0;
        pen_col    = '0;
        last_row   = '0;
        erase_lead = 7'(stp_pkg::GAP_RESET);

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        test_reset_defaults();
        test_row_scaling();
        test_gap_settings();
        test_long_backpressure();
        test_random_traces();

        if (errors == 0)
            $display("scrolling_trace_plot_commands verification clean");
        else
            $display("scrolling_trace_plot_commands verification failed");
        $finish;
    end

endmodule
